@@ rtl/jsu_pkg.sv @@
package jsu_pkg;

  // Result status codes
  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [15:0] MAX_LENGTH_RESET = 16'd4095;

  // One queued command: one or two results caused by a single input byte.
  // With two results, the first carries byte_hi and the second byte_lo.
  typedef struct packed {
    logic        two;
    logic [1:0]  status;
    logic [7:0]  byte_hi;
    logic [7:0]  byte_lo;
    logic [15:0] length;
  } cmd_t;

  // One result as presented on the output ports.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  data_byte;
    logic [15:0] length;
    logic        last;
  } res_t;

endpackage

@@ rtl/jsu_front.sv @@
module jsu_front import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_STR  = 2'd1;
  localparam logic [1:0] M_ESC  = 2'd2;
  localparam logic [1:0] M_HEX  = 2'd3;

  logic [1:0]  mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_value, hex_value_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] max_length;

  logic        emit_req, emit_two, fail_req, done_req;
  logic [7:0]  emit_hi, emit_lo;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] hex_full;
  logic [16:0] count_sum;
  logic        overflow;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (in_byte >= "0" && in_byte <= "9") begin
      hex_d = 4'(in_byte - "0");
    end else if (in_byte >= "a" && in_byte <= "f") begin
      hex_d = 4'(in_byte - "a" + 8'd10);
    end else if (in_byte >= "A" && in_byte <= "F") begin
      hex_d = 4'(in_byte - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_full = {hex_value[11:0], hex_d};

  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    hex_value_next  = hex_value;
    byte_count_next = byte_count;
    emit_req = 1'b0;
    emit_two = 1'b0;
    emit_hi  = 8'd0;
    emit_lo  = in_byte;
    fail_req = 1'b0;
    done_req = 1'b0;

    unique case (mode)
      M_IDLE: begin
        if (in_byte == " " || in_byte == 8'h09 || in_byte == 8'h0a || in_byte == 8'h0d) begin
          mode_next = M_IDLE;
        end else if (in_byte == "\"") begin
          mode_next = M_STR;
        end else begin
          fail_req = 1'b1;
        end
      end
      M_STR: begin
        if (in_byte == "\"") begin
          done_req = 1'b1;
        end else if (in_byte == "\\") begin
          mode_next = M_ESC;
        end else if (in_byte == 8'h00) begin
          fail_req = 1'b1;
        end else begin
          emit_req = 1'b1;
        end
      end
      M_ESC: begin
        if (in_byte == "\"" || in_byte == "\\" || in_byte == "/") begin
          emit_req = 1'b1;
        end else if (in_byte == "b") begin
          emit_req = 1'b1;
          emit_lo  = 8'h08;
        end else if (in_byte == "f") begin
          emit_req = 1'b1;
          emit_lo  = 8'h0c;
        end else if (in_byte == "n") begin
          emit_req = 1'b1;
          emit_lo  = 8'h0a;
        end else if (in_byte == "r") begin
          emit_req = 1'b1;
          emit_lo  = 8'h0d;
        end else if (in_byte == "t") begin
          emit_req = 1'b1;
          emit_lo  = 8'h09;
        end else if (in_byte == "u") begin
          mode_next      = M_HEX;
          hex_count_next = 2'd0;
          hex_value_next = 16'd0;
        end else begin
          fail_req = 1'b1;
        end
      end
      M_HEX: begin
        if (!hex_ok) begin
          fail_req = 1'b1;
        end else if (hex_count == 2'd3) begin
          hex_count_next = 2'd0;
          hex_value_next = 16'd0;
          emit_req       = 1'b1;
          emit_two       = (hex_full[15:8] != 8'd0);
          emit_hi        = hex_full[15:8];
          emit_lo        = hex_full[7:0];
        end else begin
          hex_value_next = hex_full;
          hex_count_next = hex_count + 2'd1;
        end
      end
      default: begin
        fail_req = 1'b1;
      end
    endcase

    // all-or-nothing length check for the bytes of one character
    count_sum = {1'b0, byte_count} + (emit_two ? 17'd2 : 17'd1);
    overflow  = emit_req && (count_sum > {1'b0, max_length});

    cmd_valid   = fail_req || done_req || emit_req;
    cmd.two     = 1'b0;
    cmd.status  = ST_DATA;
    cmd.byte_hi = 8'd0;
    cmd.byte_lo = 8'd0;
    cmd.length  = 16'd0;

    if (fail_req || overflow) begin
      cmd.status      = ST_ERR;
      mode_next       = M_IDLE;
      hex_count_next  = 2'd0;
      hex_value_next  = 16'd0;
      byte_count_next = 16'd0;
    end else if (done_req) begin
      cmd.status      = ST_DONE;
      cmd.length      = byte_count;
      mode_next       = M_IDLE;
      hex_count_next  = 2'd0;
      hex_value_next  = 16'd0;
      byte_count_next = 16'd0;
    end else if (emit_req) begin
      cmd.two         = emit_two;
      cmd.byte_hi     = emit_hi;
      cmd.byte_lo     = emit_lo;
      byte_count_next = count_sum[15:0];
      mode_next       = M_STR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      hex_count  <= 2'd0;
      hex_value  <= 16'd0;
      byte_count <= 16'd0;
      max_length <= MAX_LENGTH_RESET;
    end else begin
      if (cfg_we) begin
        max_length <= cfg_data;
      end
      if (accept) begin
        mode       <= mode_next;
        hex_count  <= hex_count_next;
        hex_value  <= hex_value_next;
        byte_count <= byte_count_next;
      end
    end
  end

  // hex digits only collect while reading a \u escape
  a_hex_idle: assert property (@(posedge clk) disable iff (rst)
    mode != M_HEX |-> (hex_count == 2'd0 && hex_value == 16'd0))
    else $error("hex state not clear outside hex mode");

  // an accepted quote in idle always opens a string
  a_open: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == M_IDLE && in_byte == "\"") |=> (mode == M_STR && byte_count == 16'd0))
    else $error("opening quote did not start a string");

endmodule

@@ rtl/jsu_queue.sv @@
module jsu_queue import jsu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic full,
  output logic nonempty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign rd_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({wr, rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr)
    else $error("write into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    !nonempty |-> !rd)
    else $error("read from empty queue");

endmodule

@@ rtl/jsu_back.sv @@
module jsu_back import jsu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_nonempty,
  input  cmd_t q_cmd,
  output logic q_rd,
  input  logic pop,
  output logic empty,
  output res_t res
);

  logic       out_valid;
  logic       have_second;
  logic [7:0] second_byte;
  logic       load;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;
  assign q_rd  = load && !have_second && q_nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      have_second <= 1'b0;
    end else if (load) begin
      if (have_second) begin
        out_valid   <= 1'b1;
        have_second <= 1'b0;
      end else begin
        out_valid   <= q_nonempty;
        have_second <= q_nonempty && q_cmd.two;
      end
    end
  end

  // payload: advance on load, hold otherwise
  always_ff @(posedge clk) begin
    if (load) begin
      if (have_second) begin
        res.status    <= ST_DATA;
        res.data_byte <= second_byte;
        res.length    <= 16'd0;
        res.last      <= 1'b1;
      end else begin
        res.status    <= q_cmd.status;
        res.data_byte <= q_cmd.two ? q_cmd.byte_hi : q_cmd.byte_lo;
        res.length    <= q_cmd.length;
        res.last      <= !q_cmd.two;
        second_byte   <= q_cmd.byte_lo;
      end
    end
  end

  a_second_after_first: assert property (@(posedge clk) disable iff (rst)
    have_second |-> (out_valid && !res.last && res.status == ST_DATA))
    else $error("second byte pending without its first");

  a_ctl_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.status != ST_DATA) |-> res.last)
    else $error("completion or error not marked last");

endmodule

@@ rtl/json_string_unescape_core.sv @@
// JSON string literal decoder. Feed raw JSON text one byte per transfer on
// push/full; decoded results come out on empty/pop. Outside a string the
// block skips space, tab, LF and CR and expects a double quote; any other
// byte there gives an error result. Inside a string each plain byte gives
// one data result (status 0), the escapes \" \\ \/ \b \f \n \r \t give
// their byte, and \uXXXX gives one byte when the value is below 0x100 or
// the high byte then the low byte otherwise (raw bytes, not UTF-8). The
// closing quote gives a completion result (status 1) with the decoded
// length. A NUL, bad escape, bad hex digit, or a character whose bytes
// would push the count past max_length gives an error (status 2) instead,
// and the string is dropped. last marks the final result of one input
// byte. Input rate is one byte per clock while the queue is not full; the
// output side moves one result per clock while pop is held, so a \u escape
// that yields two results for one input byte is absorbed by the command
// queue between decoder and result stage (QUEUE_DEPTH entries). Each
// command passes a queue entry, then the result register. Write max_length
// through cfg_we/cfg_data only while no byte or result is in flight; a new
// value applies at once, even in the middle of a string. It resets to 4095.
module json_string_unescape_core import jsu_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [7:0]  data_byte,
  output logic [15:0] length,
  output logic        last
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic q_wr;
  logic q_rd;
  cmd_t q_cmd;
  logic q_nonempty;
  res_t res;

  // accept a byte whenever the queue has room
  assign accept = push && !full;
  assign q_wr   = accept && cmd_valid;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_cmd   (cmd),
    .rd       (q_rd),
    .rd_cmd   (q_cmd),
    .full     (full),
    .nonempty (q_nonempty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_cmd      (q_cmd),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .res        (res)
  );

  assign status    = res.status;
  assign data_byte = res.data_byte;
  assign length    = res.length;
  assign last      = res.last;

  // a completion never carries a data byte, an error carries nothing
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_DATA) |-> (data_byte == 8'd0 &&
      (status == ST_DONE || length == 16'd0)))
    else $error("control result carries payload");

  // a result held against backpressure stays on the ports
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(data_byte) &&
      $stable(length) && $stable(last)))
    else $error("stalled result changed");

endmodule

@@ test/testbench.sv @@
module testbench;
  import jsu_pkg::*;

  // Decoder position inside the JSON text, mirrored by the predictor.
  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_HEX
  } decode_mode_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int MAX_GAP        = 13;
  localparam int STALL_CYCLES   = 120;   // long receiver hold-off, enough to fill the block
  localparam int SETTLE_CYCLES  = 6;     // lets the queue and result register go quiet, with some margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int PHASES         = 10;
  localparam int CHUNK_BYTES    = 65;    // two chunks per phase, about 1700 bytes in all

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        cfg_we   = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        push     = 1'b0;
  logic [7:0]  in_byte  = '0;
  logic        pop      = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  status;
  logic [7:0]  data_byte;
  logic [15:0] length;
  logic        last;

  json_string_unescape_core uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .empty    (empty),
    .pop      (pop),
    .status   (status),
    .data_byte(data_byte),
    .length   (length),
    .last     (last)
  );

  always #5 clk = ~clk;

  // Predictor state: a private copy of the decoder and its length limit.
  decode_mode_e dec_mode;
  logic [1:0]   hex_taken;
  logic [15:0]  hex_accum;
  logic [15:0]  decoded_count;
  logic [15:0]  length_limit;

  res_t       step_results[$];     // results caused by the byte being decoded
  res_t       expected_results[$]; // decoded results still owed by the block
  logic [7:0] byte_queue[$];       // JSON text waiting to be offered

  int error_count    = 0;
  int send_wait      = 0;
  int recv_wait      = 0;
  int stall_left     = 0;
  int stall_requests = 0;
  int stall_served   = 0;
  int idle_cycles    = 0;
  logic send_steady  = 1'b0;
  logic recv_steady  = 1'b0;

  string hex_chars = "0123456789abcdefABCDEF";
  string ws_chars  = " \t\n\015";
  string esc_chars = "\"\\/bfnrt";

  function automatic void add_result(logic [1:0] st, logic [7:0] db, logic [15:0] len);
    res_t r;
    r.status    = st;
    r.data_byte = db;
    r.length    = len;
    r.last      = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void clear_string();
    dec_mode      = MODE_IDLE;
    hex_taken     = '0;
    hex_accum     = '0;
    decoded_count = '0;
  endfunction

  // Drop the current string and report an error.
  function automatic void abandon_string();
    clear_string();
    add_result(ST_ERR, 8'h00, 16'h0000);
  endfunction

  // Emit one or two bytes, all or nothing under the length limit.
  function automatic void emit_bytes(int n, logic [7:0] hi, logic [7:0] lo);
    if (int'(decoded_count) + n > int'(length_limit)) begin
      abandon_string();
    end else begin
      if (n == 2) add_result(ST_DATA, hi, 16'h0000);
      add_result(ST_DATA, lo, 16'h0000);
      decoded_count = decoded_count + 16'(n);
      dec_mode      = MODE_STRING;
    end
  endfunction

  function automatic int hex_value_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Advance the predictor by one raw byte and queue the results it owes.
  function automatic void decode_byte(logic [7:0] c);
    int          d;
    logic [15:0] code;
    step_results.delete();
    case (dec_mode)
      MODE_IDLE: begin
        if (c == CH_QUOTE) begin
          clear_string();
          dec_mode = MODE_STRING;
        end else if (c != CH_SPACE && c != CH_TAB && c != CH_LF && c != CH_CR) begin
          abandon_string();
        end
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          add_result(ST_DONE, 8'h00, decoded_count);
          clear_string();
        end else if (c == CH_BSLASH) begin
          dec_mode = MODE_ESCAPE;
        end else if (c == CH_NUL) begin
          abandon_string();
        end else begin
          emit_bytes(1, 8'h00, c);
        end
      end
      MODE_ESCAPE: begin
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: emit_bytes(1, 8'h00, c);
          "b": emit_bytes(1, 8'h00, CH_BS);
          "f": emit_bytes(1, 8'h00, CH_FF);
          "n": emit_bytes(1, 8'h00, CH_LF);
          "r": emit_bytes(1, 8'h00, CH_CR);
          "t": emit_bytes(1, 8'h00, CH_TAB);
          "u": begin
            dec_mode  = MODE_HEX;
            hex_taken = '0;
            hex_accum = '0;
          end
          default: abandon_string();
        endcase
      end
      default: begin
        d = hex_value_of(c);
        if (d < 0) begin
          abandon_string();
        end else begin
          hex_accum = {hex_accum[11:0], 4'(d)};
          if (hex_taken == 2'd3) begin
            code      = hex_accum;
            hex_taken = '0;
            hex_accum = '0;
            if (code < 16'h0100) emit_bytes(1, 8'h00, code[7:0]);
            else emit_bytes(2, code[15:8], code[7:0]);
          end else begin
            hex_taken = hex_taken + 2'd1;
          end
        end
      end
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
  endfunction

  // One string literal with random content. Now and then it is cut short by
  // a bad escape, a bad hex digit or a NUL, and then it has no closing quote.
  function automatic void queue_string();
    int         n_chars;
    int         break_at;
    int         kind;
    logic       small_code;
    logic [7:0] b;
    repeat ($urandom_range(0, 2)) byte_queue.push_back(ws_chars[$urandom_range(0, 3)]);
    byte_queue.push_back(CH_QUOTE);
    n_chars  = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
    break_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_chars) : -1;
    for (int i = 0; i < n_chars || i == break_at; i++) begin
      if (i == break_at) begin
        case ($urandom_range(0, 2))
          0: begin
            byte_queue.push_back(CH_BSLASH);
            do b = 8'($urandom_range(0, 255));
            while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, "b", "f", "n", "r", "t", "u"});
            byte_queue.push_back(b);
          end
          1: begin
            byte_queue.push_back(CH_BSLASH);
            byte_queue.push_back("u");
            repeat ($urandom_range(0, 3)) byte_queue.push_back(hex_chars[$urandom_range(0, 21)]);
            do b = 8'($urandom_range(0, 255)); while (hex_value_of(b) >= 0);
            byte_queue.push_back(b);
          end
          default: byte_queue.push_back(CH_NUL);
        endcase
        return;
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
        byte_queue.push_back(b);
      end else if (kind < 80) begin
        byte_queue.push_back(CH_BSLASH);
        byte_queue.push_back(esc_chars[$urandom_range(0, 7)]);
      end else begin
        // Bias some codes below 0x100 so both the one- and two-byte forms show up.
        small_code = ($urandom_range(0, 2) == 0);
        byte_queue.push_back(CH_BSLASH);
        byte_queue.push_back("u");
        for (int k = 0; k < 4; k++) begin
          if (k < 2 && small_code) byte_queue.push_back("0");
          else byte_queue.push_back(hex_chars[$urandom_range(0, 21)]);
        end
      end
    end
    byte_queue.push_back(CH_QUOTE);
  endfunction

  // Hold until every byte is in, every result is out and the pipeline is quiet.
  task automatic wait_idle();
    do @(negedge clk);
    while (byte_queue.size() != 0 || push || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the length limit; only called while nothing is in flight.
  task automatic set_limit(logic [15:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    length_limit = v;
    @(negedge clk);
  endtask

  // Byte driver: offer the next queued byte after a random gap. push stays
  // high across back-to-back transfers, so it gets one assignment per edge.
  always @(posedge clk) begin : byte_driver
    logic next_push;
    if (rst) begin
      push <= 1'b0;
      send_wait = 0;
    end else begin
      next_push = push;
      if (push && !full) begin
        decode_byte(in_byte);
        next_push = 1'b0;
        send_wait = send_steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!next_push) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (byte_queue.size() > 0) begin
          in_byte   <= byte_queue.pop_front();
          next_push = 1'b1;
        end
      end
      push <= next_push;
    end
  end

  // Result monitor: check each transfer against the oldest expected result,
  // then drop pop for a random gap. A stall request forces a long hold-off.
  always @(posedge clk) begin : result_monitor
    res_t seen;
    res_t want;
    logic next_pop;
    if (rst) begin
      pop <= 1'b0;
      recv_wait  = 0;
      stall_left = 0;
    end else begin
      next_pop = pop;
      if (pop && !empty) begin
        seen = {status, data_byte, length, last};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d data=%02h length=%0d last=%0b",
                   $time, seen.status, seen.data_byte, seen.length, seen.last);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            $display("%0t: expected status=%0d data=%02h length=%0d last=%0b", $time,
                     want.status, want.data_byte, want.length, want.last);
            $display("%0t: actual   status=%0d data=%02h length=%0d last=%0b", $time,
                     seen.status, seen.data_byte, seen.length, seen.last);
            error_count++;
          end
        end
        recv_wait = recv_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (recv_wait > 0) next_pop = 1'b0;
      end else if (!pop) begin
        if (recv_wait > 0) recv_wait--;
        if (recv_wait == 0) next_pop = 1'b1;
      end
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        stall_left   = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        next_pop = 1'b0;
      end
      pop <= next_pop;
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int limits[PHASES] = '{65535, 1, 7, 30, 200, 4095, 2, 65535, 12, 500};
    int chunk_bytes;
    int before_size;
    length_limit = MAX_LENGTH_RESET;
    clear_string();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed text under the reset limit: whitespace skip, a null byte and a
    // two-byte code from \u escapes, the byte extremes, a completion, then
    // stray bytes in idle (NUL too), an unknown escape, a bad hex digit and
    // a NUL inside a string.
    queue_text(" \t\n");
    byte_queue.push_back(CH_CR);
    queue_text("\"\\u0000\\uFfa0");
    byte_queue.push_back(8'hFF);
    byte_queue.push_back(8'h01);
    queue_text("\"x");
    byte_queue.push_back(CH_NUL);
    queue_text("\"\\q\"\\u1g\"");
    byte_queue.push_back(CH_NUL);
    wait_idle();

    // Limit of one: a plain overflow, a two-byte code that does not fit, a
    // one-byte code that does, then leave a string open with one byte.
    set_limit(16'd1);
    queue_text("\"ab\"\\u0123\"\\u0041\"\"a");
    wait_idle();

    // Drop the limit to zero in the middle of that string: the next byte overflows.
    set_limit(16'd0);
    queue_text("b");
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      send_steady = (p % 3 == 1) || p == 3 || p == 7;
      recv_steady = (p % 4 == 2);
      set_limit(16'(limits[p]));
      // Two chunks per phase; the sender pauses in between until all results are in.
      for (int half = 0; half < 2; half++) begin
        chunk_bytes = 0;
        while (chunk_bytes < CHUNK_BYTES) begin
          before_size = byte_queue.size();
          if ($urandom_range(0, 11) == 0)
            repeat ($urandom_range(1, 3)) byte_queue.push_back(8'($urandom_range(0, 255)));
          else
            queue_string();
          chunk_bytes += byte_queue.size() - before_size;
        end
        // Hold off the receiver while the sender keeps streaming, so the block fills.
        if ((p == 3 || p == 7) && half == 0) stall_requests++;
        wait_idle();
      end
    end

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_core.sv
test/testbench.sv
